[hw/rtl/arp_header_parser_macros.svh]
// Assertion macros for the ARP header parser RTL.
`ifndef ARP_HEADER_PARSER_MACROS_SVH
`define ARP_HEADER_PARSER_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ARP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ARP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/arp_hdr_pkg.sv]
// Types and constants shared by the ARP header parser modules.
`default_nettype none

package arp_hdr_pkg;

   // Header length in bytes.
   localparam int unsigned HDR_LEN = 28;

   // Expected header contents for Ethernet / IPv4.
   localparam logic [15:0] HTYPE_ETH   = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  HLEN_MAC    = 8'd6;
   localparam logic [7:0]  PLEN_IPV4   = 8'd4;
   localparam logic [15:0] OP_REQUEST  = 16'd1;
   localparam logic [15:0] OP_REPLY    = 16'd2;

   // Address classes that are rejected.
   localparam logic [7:0]  IP_MCAST_LO = 8'd224;
   localparam logic [7:0]  IP_MCAST_HI = 8'd239;
   localparam logic [7:0]  IP_LOOPBACK = 8'd127;
   localparam logic [31:0] IP_BCAST    = 32'hFFFF_FFFF;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SHORT      = 3'd1,
      ST_BAD_SIZES  = 3'd2,
      ST_BAD_TYPES  = 3'd3,
      ST_BAD_OPCODE = 3'd4,
      ST_BAD_SENDER = 3'd5,
      ST_BAD_TARGET = 3'd6
   } status_type;

   // Input item: one frame byte.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_payload_type;

   // Captured header fields.
   typedef struct packed {
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0]  hw_addr_size;
      logic [7:0]  proto_addr_size;
      logic [15:0] opcode;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [47:0] target_mac;
      logic [31:0] target_ip;
   } hdr_fields_type;

   // Result item: status and header fields.
   typedef struct packed {
      logic [2:0]     status;
      hdr_fields_type hdr;
   } rsp_payload_type;

   // Control broadcast from the top level to every byte cell.
   typedef struct packed {
      logic       load;
      logic       clear;
      logic [7:0] data;
   } cell_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/arp_req_if.sv]
// Input channel carrying frame bytes with valid/ready handshake.
`default_nettype none

interface arp_req_if;
   logic                        valid;
   logic                        ready;
   arp_hdr_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/arp_rsp_if.sv]
// Result channel carrying parsed headers with valid/ready handshake.
`default_nettype none

interface arp_rsp_if;
   logic                        valid;
   logic                        ready;
   arp_hdr_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/arp_hdr_cell.sv]
// One header byte cell: holds a byte and passes the write token to its neighbour.
`default_nettype none

module arp_hdr_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  arp_hdr_pkg::cell_ctl_type ctl,
   input  logic                      prev_token,
   input  logic                      token_seed,
   output logic                      token_out,
   output logic [7:0]                view_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       token_ff;
   logic       token_in;

   // The cell holding the token captures the item's byte; the token then moves on.
   // A frame end empties the cell and puts the token back at the head of the row.
   always_comb begin
      byte_in  = byte_ff;
      token_in = token_ff;
      if (ctl.clear) begin
         byte_in  = 8'd0;
         token_in = token_seed;
      end else if (ctl.load) begin
         if (token_ff) begin
            byte_in = ctl.data;
         end
         token_in = prev_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff  <= 8'd0;
         token_ff <= token_seed;
      end else begin
         byte_ff  <= byte_in;
         token_ff <= token_in;
      end
   end

   // Contents as they stand once the current byte is written.
   assign view_byte = token_ff ? ctl.data : byte_ff;
   assign token_out = token_ff;

endmodule

`default_nettype wire

[hw/rtl/arp_hdr_check.sv]
// Header validation: works out the status code from the captured fields.
`default_nettype none

module arp_hdr_check (
   input  arp_hdr_pkg::hdr_fields_type hdr,
   input  logic                        short_frame,
   output logic [2:0]                  status
);

   arp_hdr_pkg::status_type st;
   logic [7:0] s0;
   logic [7:0] t0;
   logic       sender_bad;
   logic       target_bad;

   assign s0 = hdr.sender_ip[31:24];
   assign t0 = hdr.target_ip[31:24];

   // Sender may not be multicast, loopback or limited broadcast.
   assign sender_bad = (s0 >= arp_hdr_pkg::IP_MCAST_LO && s0 <= arp_hdr_pkg::IP_MCAST_HI)
                    || (s0 == arp_hdr_pkg::IP_LOOPBACK)
                    || (hdr.sender_ip == arp_hdr_pkg::IP_BCAST);

   // Target may not be multicast or limited broadcast.
   assign target_bad = (t0 >= arp_hdr_pkg::IP_MCAST_LO && t0 <= arp_hdr_pkg::IP_MCAST_HI)
                    || (hdr.target_ip == arp_hdr_pkg::IP_BCAST);

   // Checks in priority order, the first failure wins.
   always_comb begin
      if (short_frame) begin
         st = arp_hdr_pkg::ST_SHORT;
      end else if (hdr.hw_addr_size != arp_hdr_pkg::HLEN_MAC
                   || hdr.proto_addr_size != arp_hdr_pkg::PLEN_IPV4) begin
         st = arp_hdr_pkg::ST_BAD_SIZES;
      end else if (hdr.hw_type != arp_hdr_pkg::HTYPE_ETH
                   || hdr.proto_type != arp_hdr_pkg::PTYPE_IPV4) begin
         st = arp_hdr_pkg::ST_BAD_TYPES;
      end else if (hdr.opcode != arp_hdr_pkg::OP_REQUEST
                   && hdr.opcode != arp_hdr_pkg::OP_REPLY) begin
         st = arp_hdr_pkg::ST_BAD_OPCODE;
      end else if (sender_bad) begin
         st = arp_hdr_pkg::ST_BAD_SENDER;
      end else if (target_bad) begin
         st = arp_hdr_pkg::ST_BAD_TARGET;
      end else begin
         st = arp_hdr_pkg::ST_OK;
      end
   end

   assign status = st;

endmodule

`default_nettype wire

[hw/rtl/arp_header_parser.sv]
// ARP header parser top level: row of byte cells, header check and result register.
//
//  Channel   | Dir | Payload                                | Transfer
//  ----------+-----+----------------------------------------+----------------------
//  req_chan  | in  | data_byte, frame_end                   | valid & ready
//  rsp_chan  | out | status, header fields (hdr.*)          | valid & ready
//
//  One byte item is taken per cycle while req_chan.ready is high; a row of 28 cells
//  passes a write token along, so each byte lands in its own cell as it is accepted.
//  The result for a frame is registered on its last byte and shown the next cycle.
//  req_chan.ready drops only while a result waits and rsp_chan.ready is low.
//  Synchronous reset empties all cells and the result register; no clearing pass.
`default_nettype none
`include "arp_header_parser_macros.svh"

module arp_header_parser (
   input logic        clock,
   input logic        reset,
   arp_req_if.sink    req_chan,
   arp_rsp_if.source  rsp_chan
);

   localparam int unsigned HL = arp_hdr_pkg::HDR_LEN;

   logic                         req_acc;
   logic                         frame_done;
   arp_hdr_pkg::cell_ctl_type    ctl;
   logic [HL-1:0]                token_vec;
   logic [HL-1:0]                token_from;
   logic [HL-1:0]                seed_vec;
   logic [7:0]                   view_byte [HL];
   logic                         full_ff;
   logic                         full_in;
   logic                         short_frame;
   arp_hdr_pkg::hdr_fields_type  hdr;
   logic [2:0]                   status;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   arp_hdr_pkg::rsp_payload_type rsp_data_ff;
   arp_hdr_pkg::rsp_payload_type rsp_data_in;

   // Input handshake: a new item is taken whenever the result register can move.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign frame_done     = req_acc && req_chan.payload.frame_end;

   assign ctl.load  = req_acc;
   assign ctl.clear = frame_done;
   assign ctl.data  = req_chan.payload.data_byte;

   // Token enters at cell 0 and moves one cell per accepted byte.
   assign token_from = {token_vec[HL-2:0], 1'b0};
   assign seed_vec   = HL'(1);

   for (genvar i = 0; i < HL; i++) begin : g_cell
      arp_hdr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_token (token_from[i]),
         .token_seed (seed_vec[i]),
         .token_out  (token_vec[i]),
         .view_byte  (view_byte[i])
      );
   end

   // Saturation flag: set once the last cell has taken its byte.
   always_comb begin
      full_in = full_ff;
      if (frame_done) begin
         full_in = 1'b0;
      end else if (req_acc && token_vec[HL-1]) begin
         full_in = 1'b1;
      end
   end

   // Frame is short unless the last cell is filled by now or by this byte.
   assign short_frame = !(full_ff || token_vec[HL-1]);

   // Assemble the header fields, big-endian.
   assign hdr.hw_type         = {view_byte[0], view_byte[1]};
   assign hdr.proto_type      = {view_byte[2], view_byte[3]};
   assign hdr.hw_addr_size    = view_byte[4];
   assign hdr.proto_addr_size = view_byte[5];
   assign hdr.opcode          = {view_byte[6], view_byte[7]};
   assign hdr.sender_mac      = {view_byte[8], view_byte[9], view_byte[10],
                                 view_byte[11], view_byte[12], view_byte[13]};
   assign hdr.sender_ip       = {view_byte[14], view_byte[15], view_byte[16], view_byte[17]};
   assign hdr.target_mac      = {view_byte[18], view_byte[19], view_byte[20],
                                 view_byte[21], view_byte[22], view_byte[23]};
   assign hdr.target_ip       = {view_byte[24], view_byte[25], view_byte[26], view_byte[27]};

   arp_hdr_check u_check (
      .hdr         (hdr),
      .short_frame (short_frame),
      .status      (status)
   );

   // Result register: loads on a frame end, empties when the item is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (frame_done) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.status = status;
         rsp_data_in.hdr    = hdr;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Exactly one of the cells holds the token, or the row is full.
   `ARP_ASSERT_IMPL(a_token_onehot, clock, reset, 1'b1, $onehot({full_ff, token_vec}), "token lost or duplicated")
   // A frame end always leaves a result waiting in the next cycle.
   `ARP_ASSERT_NEXT(a_rsp_loaded, clock, reset, frame_done, rsp_valid_ff, "frame end gave no result")
   // After a frame end the row restarts at its head cell.
   `ARP_ASSERT_NEXT(a_row_cleared, clock, reset, frame_done, token_vec[0] && !full_ff, "row not cleared after frame")

endmodule

`default_nettype wire
